// ===== design/multi_channel_tick_timer_assert.svh =====
// Assertion macros used by the timer bank controller
`ifndef MULTI_CHANNEL_TICK_TIMER_ASSERT_SVH
`define MULTI_CHANNEL_TICK_TIMER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define MCTT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define MCTT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mctt_pkg.sv =====
// Types and constants of the tick timer bank
package mctt_pkg;

    localparam int TIMERS  = 16;
    localparam int IDX_W   = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int SLOT_W  = 4;
    localparam int CMP_W   = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int TICK_W  = 32;
    localparam int MAX_RES = 16;
    localparam int NREP_W  = $clog2(MAX_RES + 1);

    typedef enum logic [2:0] {
        MODE_TICK    = 3'd0,
        MODE_CREATE  = 3'd1,
        MODE_START   = 3'd2,
        MODE_STOP    = 3'd3,
        MODE_RELEASE = 3'd4,
        MODE_SET     = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_UNUSED  = 2'd2
    } t_status;

    // Command broadcast to every cell; strobes are high only in the accept cycle
    typedef struct packed {
        logic              create;
        logic              start;
        logic              stop;
        logic              rel;
        logic              set_cnt;
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] ticks;
        logic              run;
    } t_cmd;

    typedef struct packed {
        logic hit;        // addressed slot is in use
        logic pick;       // this cell is claimed by create or fires now
        logic fire;       // fires during this walk step
        logic fire_last;  // fires and no later cell will fire on this tick
    } t_cell_stat;

    typedef struct packed {
        logic              hit;
        logic              found;
        logic              fire;
        logic              fire_last;
        logic              done;
        logic [SLOT_W-1:0] idx;
    } t_bank_stat;

endpackage

// ===== design/mctt_cell.sv =====
// One timer slot: state, command decode and the tick token stage
module mctt_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [mctt_pkg::IDX_W-1:0] i_idx,
    input  mctt_pkg::t_cmd           i_cmd,
    input  logic                     i_inject,
    input  logic                     i_step,
    input  logic                     i_tok,
    output logic                     o_tok,
    input  logic                     i_taken,
    output logic                     o_taken,
    input  logic                     i_later,
    output logic                     o_later,
    output mctt_pkg::t_cell_stat     o_stat
);
    import mctt_pkg::*;

    logic              r_tok;
    logic              r_in_use;
    logic              r_active;
    logic [TICK_W-1:0] r_rem;
    logic [TICK_W-1:0] r_per;
    logic [TICK_W-1:0] n_rem;

    logic sel;
    logic hit;
    logic claim;
    logic will_fire;
    logic visit;

    assign sel       = (CMP_W'(i_cmd.slot) == CMP_W'(i_idx));
    assign hit       = sel & r_in_use;
    assign claim     = i_cmd.create & ~r_in_use & ~i_taken;
    // count of zero or one reaches zero on this tick
    assign will_fire = r_in_use & r_active & (r_rem[TICK_W-1:1] == '0);
    assign visit     = i_step & r_tok & r_in_use;

    assign o_tok   = r_tok;
    assign o_taken = i_taken | ~r_in_use;
    assign o_later = i_later | will_fire;

    assign o_stat.hit       = hit;
    assign o_stat.fire      = visit & will_fire;
    assign o_stat.fire_last = visit & will_fire & ~i_later;
    assign o_stat.pick      = claim | (visit & will_fire);

    always_comb begin
        n_rem = r_rem;
        if (claim) begin
            n_rem = i_cmd.ticks;
        end else if (hit && i_cmd.set_cnt) begin
            n_rem = i_cmd.ticks;
        end else if (visit) begin
            if (will_fire) begin
                n_rem = r_per;
            end else if (r_rem != '0) begin
                n_rem = r_rem - TICK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok    <= 1'b0;
            r_in_use <= 1'b0;
            r_active <= 1'b0;
        end else begin
            if (i_inject || i_step) begin
                r_tok <= i_tok;
            end
            if (claim) begin
                r_in_use <= 1'b1;
                r_active <= i_cmd.run;
            end else if (hit) begin
                if (i_cmd.start) begin
                    r_active <= 1'b1;
                end
                if (i_cmd.stop) begin
                    r_active <= 1'b0;
                end
                if (i_cmd.rel) begin
                    r_in_use <= 1'b0;
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        if (claim) begin
            r_per <= i_cmd.ticks;
        end
    end

endmodule

// ===== design/mctt_ctrl.sv =====
// Request handshake, tick walk control and the result register
module mctt_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [2:0]                i_mode,
    input  logic [mctt_pkg::SLOT_W-1:0] i_slot,
    input  logic [mctt_pkg::TICK_W-1:0] i_ticks,
    input  logic                      i_run,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_status,
    output logic [mctt_pkg::SLOT_W-1:0] o_timer_index,
    output logic                      o_fired,
    output logic                      o_last,
    input  mctt_pkg::t_bank_stat      i_bank,
    output mctt_pkg::t_cmd            o_cmd,
    output logic                      o_inject,
    output logic                      o_step
);
    import mctt_pkg::*;

    logic              r_busy;
    logic [NREP_W-1:0] r_nrep;
    logic              r_out_valid;
    logic [1:0]        r_status;
    logic [SLOT_W-1:0] r_idx;
    logic              r_fired;
    logic              r_last;

    logic              ld;
    logic [1:0]        n_status;
    logic [SLOT_W-1:0] n_idx;
    logic              n_fired;
    logic              n_last;

    logic  out_free;
    logic  accept;
    logic  is_tick;
    logic  cmd_acc;
    logic  report;
    logic  quiet;
    t_mode mode;

    assign mode     = t_mode'(i_mode);
    assign out_free = ~r_out_valid | ~i_out_stall;
    assign o_in_stall = r_busy | ~out_free;
    assign accept   = i_in_valid & ~o_in_stall;
    assign is_tick  = (mode == MODE_TICK);
    assign cmd_acc  = accept & ~is_tick;
    assign o_inject = accept & is_tick;
    assign o_step   = r_busy & out_free;

    assign report = o_step & i_bank.fire & (r_nrep < NREP_W'(MAX_RES));
    assign quiet  = o_step & i_bank.done & ~i_bank.fire & (r_nrep == '0);

    assign o_cmd.create  = cmd_acc & (mode == MODE_CREATE);
    assign o_cmd.start   = cmd_acc & (mode == MODE_START);
    assign o_cmd.stop    = cmd_acc & (mode == MODE_STOP);
    assign o_cmd.rel     = cmd_acc & (mode == MODE_RELEASE);
    assign o_cmd.set_cnt = cmd_acc & (mode == MODE_SET);
    assign o_cmd.slot    = i_slot;
    assign o_cmd.ticks   = i_ticks;
    assign o_cmd.run     = i_run;

    always_comb begin
        ld       = 1'b0;
        n_status = ST_OK;
        n_idx    = '0;
        n_fired  = 1'b0;
        n_last   = 1'b1;
        priority if (cmd_acc) begin
            ld = 1'b1;
            unique case (mode)
                MODE_CREATE: begin
                    n_status = i_bank.found ? ST_OK : ST_NO_FREE;
                    n_idx    = i_bank.found ? i_bank.idx : '0;
                end
                MODE_START, MODE_STOP, MODE_RELEASE, MODE_SET: begin
                    n_status = i_bank.hit ? ST_OK : ST_UNUSED;
                    n_idx    = i_slot;
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end else if (report) begin
            ld      = 1'b1;
            n_idx   = i_bank.idx;
            n_fired = 1'b1;
            // close the list at the last fire or at the report limit
            n_last  = i_bank.fire_last | (r_nrep == NREP_W'(MAX_RES - 1));
        end else if (quiet) begin
            ld = 1'b1;
        end else begin
            ld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_nrep      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_inject) begin
                r_busy <= 1'b1;
                r_nrep <= '0;
            end else begin
                if (o_step && i_bank.done) begin
                    r_busy <= 1'b0;
                end
                if (report) begin
                    r_nrep <= r_nrep + NREP_W'(1);
                end
            end
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_status <= n_status;
            r_idx    <= n_idx;
            r_fired  <= n_fired;
            r_last   <= n_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_timer_index = r_idx;
    assign o_fired       = r_fired;
    assign o_last        = r_last;

`include "multi_channel_tick_timer_assert.svh"

    `MCTT_ASSERT_NXT(a_walk_starts, o_inject, r_busy && r_nrep == '0, "tick walk did not start")
    `MCTT_ASSERT_NXT(a_walk_ends, o_step && i_bank.done, !r_busy, "tick walk did not end")
    `MCTT_ASSERT_IMP(a_fire_in_walk, i_bank.fire, o_step, "slot fired outside a walk step")
    `MCTT_ASSERT_IMP(a_nrep_cap, 1'b1, r_nrep <= NREP_W'(MAX_RES), "fire report count overran")
    `MCTT_ASSERT_NXT(a_quiet_result, quiet, o_out_valid && o_last && !o_fired, "quiet tick lost")

endmodule

// ===== design/multi_channel_tick_timer.sv =====
// Top level of the tick timer bank: cell row and controller
// A bank of TIMERS timer slots, one cell each. Create, start, stop, release
// and set count requests each give one result. A tick request sends a token
// down the row of cells, one cell per cycle, pausing while a finished result
// is not taken, and holds the input until the walk ends. Each visited slot
// counts down and, when running and at one or zero, reloads and reports a
// fire; fires come out in slot order, the final one flagged last, and a tick
// with no fires gives one result with fired low. Requests are accepted while
// a result waits, as long as the result register can drain.
module multi_channel_tick_timer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [2:0]                i_mode,
    input  logic [mctt_pkg::SLOT_W-1:0] i_slot,
    input  logic [mctt_pkg::TICK_W-1:0] i_ticks,
    input  logic                      i_run,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_status,
    output logic [mctt_pkg::SLOT_W-1:0] o_timer_index,
    output logic                      o_fired,
    output logic                      o_last
);
    import mctt_pkg::*;

    logic [TIMERS:0] tok;
    logic [TIMERS:0] taken;
    logic [TIMERS:0] later;
    t_cell_stat      stat [TIMERS];
    t_bank_stat      bank;
    t_cmd            cmd;
    logic            inject;
    logic            step;

    assign tok[0]        = inject;
    assign taken[0]      = 1'b0;
    assign later[TIMERS] = 1'b0;

    for (genvar g = 0; g < TIMERS; g++) begin : g_cell
        mctt_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (IDX_W'(g)),
            .i_cmd    (cmd),
            .i_inject (inject),
            .i_step   (step),
            .i_tok    (tok[g]),
            .o_tok    (tok[g+1]),
            .i_taken  (taken[g]),
            .o_taken  (taken[g+1]),
            .i_later  (later[g+1]),
            .o_later  (later[g]),
            .o_stat   (stat[g])
        );
    end

    // merge cell status; at most one cell picks in any cycle
    always_comb begin
        bank       = '0;
        bank.found = taken[TIMERS];
        bank.done  = tok[TIMERS];
        for (int k = 0; k < TIMERS; k++) begin
            bank.hit       = bank.hit | stat[k].hit;
            bank.fire      = bank.fire | stat[k].fire;
            bank.fire_last = bank.fire_last | stat[k].fire_last;
            if (stat[k].pick) begin
                bank.idx = bank.idx | SLOT_W'(k);
            end
        end
    end

    mctt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_slot        (i_slot),
        .i_ticks       (i_ticks),
        .i_run         (i_run),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_timer_index (o_timer_index),
        .o_fired       (o_fired),
        .o_last        (o_last),
        .i_bank        (bank),
        .o_cmd         (cmd),
        .o_inject      (inject),
        .o_step        (step)
    );

endmodule
